// ===== design/line_framer_with_flood_limit_defines.svh =====
// Assertion helpers shared by the line framer RTL.
`ifndef LINE_FRAMER_WITH_FLOOD_LIMIT_DEFINES_SVH
`define LINE_FRAMER_WITH_FLOOD_LIMIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LF_CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line framer check failed");

// Next-cycle implication, disabled during reset.
`define LF_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line framer check failed");

`endif

// ===== design/lf_pkg.sv =====
package lf_pkg;

   localparam int LEN_W        = 6;
   localparam int MAX_LINE_DEF = 63;
   localparam int LINES_W      = 10;
   localparam int CNT_W        = 32;
   localparam int KIND_W       = 3;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 10;

   localparam logic [CNT_W-1:0] WINDOW_MS = 32'd1000;
   localparam logic [7:0]       CH_NL     = 8'd10;
   localparam logic [7:0]       CH_CR     = 8'd13;

   localparam logic [KIND_W-1:0] KIND_ECHO     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FRAME    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OVERLONG = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLOOD    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ON   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LINES = 2'd3;

   typedef struct packed {
      logic shift;
      logic load;
   } lf_cell_ctl_type;

   typedef struct packed {
      logic               check;
      logic [CNT_W-1:0]   now_ms;
      logic [LINES_W-1:0] max_lines;
   } lf_lim_req_type;

endpackage

// ===== design/lf_cell.sv =====
module lf_cell
   import lf_pkg::*;
(
   input  logic            clock,
   input  lf_cell_ctl_type ctl,
   input  logic [7:0]      load_byte,
   input  logic [7:0]      next_byte,
   output logic [7:0]      cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // A write from the receive side wins; otherwise the cell takes its neighbor's byte on a shift.
   always_comb begin
      byte_in = byte_ff;
      if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== design/lf_limiter.sv =====
module lf_limiter
   import lf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lf_lim_req_type lim_req,
   output logic           allowed
);

   logic [CNT_W-1:0]   win_start_ff;
   logic [CNT_W-1:0]   win_start_in;
   logic [LINES_W-1:0] lines_ff;
   logic [LINES_W-1:0] lines_in;
   logic [CNT_W-1:0]   elapsed;
   logic               expired;
   logic [LINES_W-1:0] lines_eff;

   // The window restarts at the time of the first newline that finds it expired.
   assign elapsed   = lim_req.now_ms - win_start_ff;
   assign expired   = elapsed >= WINDOW_MS;
   assign lines_eff = expired ? '0 : lines_ff;
   assign allowed   = lines_eff < lim_req.max_lines;

   always_comb begin
      win_start_in = win_start_ff;
      lines_in     = lines_ff;
      if (lim_req.check) begin
         if (expired) begin
            win_start_in = lim_req.now_ms;
         end
         lines_in = allowed ? lines_eff + 1'b1 : lines_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         lines_ff     <= '0;
      end else begin
         win_start_ff <= win_start_in;
         lines_ff     <= lines_in;
      end
   end

endmodule

// ===== design/line_framer_with_flood_limit.sv =====
// Newline-delimited line framer with a flood limit. Each transfer on the req_ channel
// carries one received byte and the current millisecond time; the block collects bytes in a
// chain of MAX_LINE byte cells and, on a newline, either drops the line (rate limit of
// max_lines_per_window lines per 1000 ms window) or plays it out on the rsp_ channel one
// byte per cycle while the output register is free, with one trailing carriage return
// removed, or as an empty-frame marker. A byte other than a newline that finds the line at
// its length limit produces an overlong marker. With echo_on set every byte is first
// returned as an echo result. A new byte is taken only once every result of the last one
// has moved into the output register, and each frame byte that moves there shifts the cell
// chain one byte toward the output. The csr_ port is always ready; configuration is meant
// to change only while the block is idle.
`include "line_framer_with_flood_limit_defines.svh"

module line_framer_with_flood_limit
   import lf_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Received bytes
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   input  logic [CNT_W-1:0]      req_now_ms,
   // Results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last_of_frame,
   output logic [LEN_W-1:0]      rsp_frame_length,
   output logic [CNT_W-1:0]      rsp_bytes_received,
   output logic [CNT_W-1:0]      rsp_frames_received,
   output logic [CNT_W-1:0]      rsp_overlong_count,
   output logic [CNT_W-1:0]      rsp_flood_drop_count,
   // Configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Sequencer states. IDLE is the only state that takes a new byte.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ECHO   = 2'd1;
   localparam logic [1:0] ST_MARK   = 2'd2;
   localparam logic [1:0] ST_STREAM = 2'd3;

   // Configuration registers.
   logic               enable_ff;
   logic               echo_on_ff;
   logic [LEN_W-1:0]   max_len_ff;
   logic [LINES_W-1:0] max_lines_ff;

   // Line and sequencer state.
   logic [1:0]        state_ff, state_in;
   logic [1:0]        pend_ff, pend_in;
   logic [KIND_W-1:0] marker_ff, marker_in;
   logic [7:0]        echo_byte_ff, echo_byte_in;
   logic [LEN_W-1:0]  line_len_ff, line_len_in;
   logic              cr_last_ff, cr_last_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [LEN_W-1:0]  flen_ff, flen_in;

   // Statistics counters.
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [CNT_W-1:0] frame_cnt_ff, frame_cnt_in;
   logic [CNT_W-1:0] over_cnt_ff, over_cnt_in;
   logic [CNT_W-1:0] flood_cnt_ff, flood_cnt_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]  rsp_flen_ff, rsp_flen_in;
   logic [CNT_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic [CNT_W-1:0]  rsp_frames_ff, rsp_frames_in;
   logic [CNT_W-1:0]  rsp_over_ff, rsp_over_in;
   logic [CNT_W-1:0]  rsp_flood_ff, rsp_flood_in;

   logic             req_fire;
   logic             csr_fire;
   logic             is_nl;
   logic [LEN_W-1:0] limit;
   logic             cr_strip;
   logic [LEN_W-1:0] eff_len;
   logic             append;
   logic             shift;
   logic             out_free;
   logic             out_load;
   logic [1:0]       next_st;
   logic             allowed;
   lf_lim_req_type   lim_req;
   logic [7:0]       cell_q [MAX_LINE];

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_nl     = req_rx_byte == CH_NL;

   // The effective length limit is the smaller of the register and the store depth.
   assign limit = (max_len_ff < LEN_W'(MAX_LINE)) ? max_len_ff : LEN_W'(MAX_LINE);

   // A carriage return is remembered as it is stored, so the last byte never needs a lookup.
   assign cr_strip = (line_len_ff != '0) && cr_last_ff;
   assign eff_len  = line_len_ff - LEN_W'(cr_strip);

   assign lim_req.check     = req_fire && enable_ff && is_nl;
   assign lim_req.now_ms    = req_now_ms;
   assign lim_req.max_lines = max_lines_ff;

   lf_limiter u_limiter (
      .clock   (clock),
      .reset   (reset),
      .lim_req (lim_req),
      .allowed (allowed)
   );

   // The line store is a chain of byte cells. A received byte is written into the cell at
   // the current line length; during playout every cell takes its upper neighbor's byte, so
   // the frame leaves the chain from cell zero in order.
   for (genvar i = 0; i < MAX_LINE; i++) begin : g_cell
      lf_cell_ctl_type ctl;
      logic [7:0]      next_byte;

      assign ctl.shift = shift;
      assign ctl.load  = append && (line_len_ff == LEN_W'(i));

      if (i == MAX_LINE - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_link
         assign next_byte = cell_q[i+1];
      end

      lf_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_byte (req_rx_byte),
         .next_byte (next_byte),
         .cell_byte (cell_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      marker_in     = marker_ff;
      echo_byte_in  = echo_byte_ff;
      line_len_in   = line_len_ff;
      cr_last_in    = cr_last_ff;
      remain_in     = remain_ff;
      flen_in       = flen_ff;
      byte_cnt_in   = byte_cnt_ff;
      frame_cnt_in  = frame_cnt_ff;
      over_cnt_in   = over_cnt_ff;
      flood_cnt_in  = flood_cnt_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_flen_in   = rsp_flen_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_over_in   = rsp_over_ff;
      rsp_flood_in  = rsp_flood_ff;
      append        = 1'b0;
      shift         = 1'b0;
      out_load      = 1'b0;
      next_st       = ST_IDLE;

      // Accepting a byte settles the whole step at once: the counters take their final
      // values here and the sequencer is armed with the results still to be delivered.
      if (req_fire) begin
         if (!enable_ff) begin
            line_len_in = '0;
         end else begin
            byte_cnt_in  = byte_cnt_ff + 1'b1;
            echo_byte_in = req_rx_byte;
            if (is_nl) begin
               line_len_in = '0;
               if (!allowed) begin
                  flood_cnt_in = flood_cnt_ff + 1'b1;
                  marker_in    = KIND_FLOOD;
                  next_st      = ST_MARK;
               end else begin
                  frame_cnt_in = frame_cnt_ff + 1'b1;
                  if (eff_len == '0) begin
                     marker_in = KIND_EMPTY;
                     next_st   = ST_MARK;
                  end else begin
                     remain_in = eff_len;
                     flen_in   = eff_len;
                     next_st   = ST_STREAM;
                  end
               end
            end else if (line_len_ff >= limit) begin
               over_cnt_in = over_cnt_ff + 1'b1;
               line_len_in = '0;
               marker_in   = KIND_OVERLONG;
               next_st     = ST_MARK;
            end else begin
               append      = 1'b1;
               line_len_in = line_len_ff + 1'b1;
               cr_last_in  = req_rx_byte == CH_CR;
            end
            if (echo_on_ff) begin
               state_in = ST_ECHO;
               pend_in  = next_st;
            end else begin
               state_in = next_st;
            end
         end
      end

      // One result moves into the output register per cycle whenever that register is free.
      if (out_free && (state_ff != ST_IDLE)) begin
         out_load      = 1'b1;
         rsp_data_in   = '0;
         rsp_last_in   = 1'b0;
         rsp_flen_in   = '0;
         rsp_bytes_in  = byte_cnt_ff;
         rsp_frames_in = frame_cnt_ff;
         rsp_over_in   = over_cnt_ff;
         rsp_flood_in  = flood_cnt_ff;
         case (state_ff)
            ST_ECHO: begin
               rsp_kind_in = KIND_ECHO;
               rsp_data_in = echo_byte_ff;
               state_in    = pend_ff;
            end
            ST_MARK: begin
               rsp_kind_in = marker_ff;
               rsp_last_in = marker_ff == KIND_EMPTY;
               state_in    = ST_IDLE;
            end
            ST_STREAM: begin
               rsp_kind_in = KIND_FRAME;
               rsp_data_in = cell_q[0];
               rsp_last_in = remain_ff == LEN_W'(1);
               rsp_flen_in = flen_ff;
               shift       = 1'b1;
               remain_in   = remain_ff - 1'b1;
               if (remain_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               rsp_kind_in = KIND_ECHO;
               state_in    = ST_IDLE;
            end
         endcase
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // Turning the block off empties the line store.
      if (csr_fire && (csr_index == CSR_ENABLE) && !csr_wdata[0]) begin
         line_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         echo_on_ff   <= 1'b0;
         max_len_ff   <= LEN_W'(63);
         max_lines_ff <= LINES_W'(30);
      end else if (csr_fire) begin
         case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_ECHO_ON:   echo_on_ff   <= csr_wdata[0];
            CSR_MAX_LEN:   max_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_MAX_LINES: max_lines_ff <= csr_wdata[LINES_W-1:0];
            default:       enable_ff    <= enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= ST_IDLE;
         line_len_ff  <= '0;
         cr_last_ff   <= 1'b0;
         remain_ff    <= '0;
         byte_cnt_ff  <= '0;
         frame_cnt_ff <= '0;
         over_cnt_ff  <= '0;
         flood_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         line_len_ff  <= line_len_in;
         cr_last_ff   <= cr_last_in;
         remain_ff    <= remain_in;
         byte_cnt_ff  <= byte_cnt_in;
         frame_cnt_ff <= frame_cnt_in;
         over_cnt_ff  <= over_cnt_in;
         flood_cnt_ff <= flood_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      marker_ff     <= marker_in;
      echo_byte_ff  <= echo_byte_in;
      flen_ff       <= flen_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_flen_ff   <= rsp_flen_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_over_ff   <= rsp_over_in;
      rsp_flood_ff  <= rsp_flood_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_data_byte        = rsp_data_ff;
   assign rsp_last_of_frame    = rsp_last_ff;
   assign rsp_frame_length     = rsp_flen_ff;
   assign rsp_bytes_received   = rsp_bytes_ff;
   assign rsp_frames_received  = rsp_frames_ff;
   assign rsp_overlong_count   = rsp_over_ff;
   assign rsp_flood_drop_count = rsp_flood_ff;

   // No new byte may enter while a frame is still leaving the cell chain.
   `LF_CHECK_NOW(a_stream_blocks_input, clock, reset, state_ff == ST_STREAM, !req_ready)
   // A frame byte always belongs to a frame of nonzero length.
   `LF_CHECK_NOW(a_frame_len_nonzero, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == KIND_FRAME), rsp_flen_ff != '0)
   // The end-of-frame flag only appears on frame bytes and empty-frame markers.
   `LF_CHECK_NOW(a_last_kind, clock, reset, rsp_valid_ff && rsp_last_ff,
      (rsp_kind_ff == KIND_FRAME) || (rsp_kind_ff == KIND_EMPTY))
   // Loading the final frame byte returns the sequencer to idle.
   `LF_CHECK_NEXT(a_stream_ends, clock, reset,
      out_load && (state_ff == ST_STREAM) && (remain_ff == LEN_W'(1)), state_ff == ST_IDLE)

endmodule

// ===== test/line_framer_with_flood_limit_checker.sv =====
module line_framer_with_flood_limit_checker
   import lf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   input  logic [CNT_W-1:0]      req_now_ms,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic [7:0]            rsp_data_byte,
   input  logic                  rsp_last_of_frame,
   input  logic [LEN_W-1:0]      rsp_frame_length,
   input  logic [CNT_W-1:0]      rsp_bytes_received,
   input  logic [CNT_W-1:0]      rsp_frames_received,
   input  logic [CNT_W-1:0]      rsp_overlong_count,
   input  logic [CNT_W-1:0]      rsp_flood_drop_count,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data_byte;
      logic              last_of_frame;
      logic [LEN_W-1:0]  frame_length;
      logic [CNT_W-1:0]  bytes_received;
      logic [CNT_W-1:0]  frames_received;
      logic [CNT_W-1:0]  overlong_count;
      logic [CNT_W-1:0]  flood_drop_count;
   } line_result_type;

   line_result_type due_results[$];

   logic [7:0]         line_buf [MAX_LINE_DEF];
   logic [LEN_W-1:0]   line_len;
   logic [CNT_W-1:0]   window_start;
   logic [LINES_W-1:0] window_lines;
   logic [CNT_W-1:0]   byte_total;
   logic [CNT_W-1:0]   frame_total;
   logic [CNT_W-1:0]   overlong_total;
   logic [CNT_W-1:0]   flood_total;

   logic               cfg_enable;
   logic               cfg_echo;
   logic [LEN_W-1:0]   cfg_max_len;
   logic [LINES_W-1:0] cfg_max_lines;

   task automatic clear_line_state();
      line_len       = '0;
      window_start   = '0;
      window_lines   = '0;
      byte_total     = '0;
      frame_total    = '0;
      overlong_total = '0;
      flood_total    = '0;
      cfg_enable     = 1'b1;
      cfg_echo       = 1'b0;
      cfg_max_len    = 6'd63;
      cfg_max_lines  = 10'd30;
      error_count    = 0;
      due_results.delete();
   endtask

   task automatic write_cfg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_ENABLE: begin
            cfg_enable = val[0];
            if (!val[0]) line_len = '0;
         end
         CSR_ECHO_ON:   cfg_echo = val[0];
         CSR_MAX_LEN:   cfg_max_len = val[LEN_W-1:0];
         CSR_MAX_LINES: cfg_max_lines = val[LINES_W-1:0];
         default: ;
      endcase
   endtask

   // Works out every result that one received byte causes and queues them.
   task automatic predict_byte(input logic [7:0] b, input logic [CNT_W-1:0] now);
      line_result_type step_results[$];
      line_result_type r;
      int              limit;
      int              out_len;
      if (!cfg_enable) begin
         line_len = '0;
         return;
      end
      byte_total++;
      if (cfg_echo) begin
         r = '0;
         r.kind = KIND_ECHO;
         r.data_byte = b;
         step_results.push_back(r);
      end
      limit = (cfg_max_len < MAX_LINE_DEF) ? int'(cfg_max_len) : MAX_LINE_DEF;
      if (b == CH_NL) begin
         // The window restarts once a full second has passed, with modular time.
         if (now - window_start >= WINDOW_MS) begin
            window_start = now;
            window_lines = '0;
         end
         if (window_lines >= cfg_max_lines) begin
            flood_total++;
            r = '0;
            r.kind = KIND_FLOOD;
            step_results.push_back(r);
         end else begin
            window_lines++;
            out_len = line_len;
            if (out_len > 0 && line_buf[out_len - 1] == CH_CR) out_len--;
            frame_total++;
            if (out_len == 0) begin
               r = '0;
               r.kind = KIND_EMPTY;
               r.last_of_frame = 1'b1;
               step_results.push_back(r);
            end else begin
               for (int j = 0; j < out_len; j++) begin
                  r = '0;
                  r.kind = KIND_FRAME;
                  r.data_byte = line_buf[j];
                  r.last_of_frame = (j == out_len - 1);
                  r.frame_length = out_len[LEN_W-1:0];
                  step_results.push_back(r);
               end
            end
         end
         line_len = '0;
      end else if (int'(line_len) >= limit) begin
         overlong_total++;
         line_len = '0;
         r = '0;
         r.kind = KIND_OVERLONG;
         step_results.push_back(r);
      end else begin
         line_buf[line_len] = b;
         line_len++;
      end
      // Every result of the step carries the counters as they stand after it.
      foreach (step_results[i]) begin
         r = step_results[i];
         r.bytes_received   = byte_total;
         r.frames_received  = frame_total;
         r.overlong_count   = overlong_total;
         r.flood_drop_count = flood_total;
         due_results.push_back(r);
      end
   endtask

   task automatic check_result(input line_result_type seen);
      line_result_type want;
      if (due_results.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: unexpected result kind %0d data %02h", $realtime,
                     seen.kind, seen.data_byte);
         return;
      end
      want = due_results.pop_front();
      if (seen !== want) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: mismatch want kind %0d data %02h last %0b len %0d cnt %0d %0d %0d %0d",
                     $realtime, want.kind, want.data_byte, want.last_of_frame,
                     want.frame_length, want.bytes_received, want.frames_received,
                     want.overlong_count, want.flood_drop_count);
            $display("%0t:          got kind %0d data %02h last %0b len %0d cnt %0d %0d %0d %0d",
                     $realtime, seen.kind, seen.data_byte, seen.last_of_frame,
                     seen.frame_length, seen.bytes_received, seen.frames_received,
                     seen.overlong_count, seen.flood_drop_count);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      line_result_type seen;
      if (reset) begin
         clear_line_state();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.kind             = rsp_kind;
            seen.data_byte        = rsp_data_byte;
            seen.last_of_frame    = rsp_last_of_frame;
            seen.frame_length     = rsp_frame_length;
            seen.bytes_received   = rsp_bytes_received;
            seen.frames_received  = rsp_frames_received;
            seen.overlong_count   = rsp_overlong_count;
            seen.flood_drop_count = rsp_flood_drop_count;
            check_result(seen);
         end
         if (csr_valid && csr_ready) write_cfg(csr_index, csr_wdata);
         if (req_valid && req_ready) predict_byte(req_rx_byte, req_now_ms);
      end
      pending = due_results.size();
   end

endmodule

// ===== test/line_framer_with_flood_limit_test.sv =====
module line_framer_with_flood_limit_test
   import lf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles to let the block finish any silent work before a register write,
   // and to linger at the end for stray results.
   localparam int SETTLE_CYCLES   = 80;
   // The watchdog ends the run after this many cycles without any transfer.
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int NUM_PHASES      = 5;
   localparam int ITEMS_PER_PHASE = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_rx_byte = '0;
   logic [CNT_W-1:0]      req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [7:0]            rsp_data_byte;
   logic                  rsp_last_of_frame;
   logic [LEN_W-1:0]      rsp_frame_length;
   logic [CNT_W-1:0]      rsp_bytes_received;
   logic [CNT_W-1:0]      rsp_frames_received;
   logic [CNT_W-1:0]      rsp_overlong_count;
   logic [CNT_W-1:0]      rsp_flood_drop_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int pending;
   int quiet_cycles = 0;

   // Stimulus bookkeeping: the running millisecond time, the number of bytes
   // sent in the current random phase, and the length of a no-gap burst.
   logic [CNT_W-1:0] ms_now = '0;
   int               phase_sent = 0;
   int               burst_left = 0;
   int               ready_hold = 0;

   always #5 clock = ~clock;

   line_framer_with_flood_limit uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_last_of_frame    (rsp_last_of_frame),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_bytes_received   (rsp_bytes_received),
      .rsp_frames_received  (rsp_frames_received),
      .rsp_overlong_count   (rsp_overlong_count),
      .rsp_flood_drop_count (rsp_flood_drop_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   line_framer_with_flood_limit_checker frame_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_last_of_frame    (rsp_last_of_frame),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_bytes_received   (rsp_bytes_received),
      .rsp_frames_received  (rsp_frames_received),
      .rsp_overlong_count   (rsp_overlong_count),
      .rsp_flood_drop_count (rsp_flood_drop_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .error_count          (error_count),
      .pending              (pending)
   );

   // The receiver switches between spells of steady readiness, short bursts,
   // short stalls and the occasional long stall, so that back-pressure lands
   // on every beat of a frame, including its first and last bytes.
   always @(negedge clock) begin
      int roll;
      if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            rsp_ready = 1'b1;
            ready_hold = $urandom_range(40, 150);
         end else if (roll < 60) begin
            rsp_ready = 1'b1;
            ready_hold = $urandom_range(0, 4);
         end else if (roll < 95) begin
            rsp_ready = 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_ready = 1'b0;
            ready_hold = $urandom_range(10, 40);
         end
      end
   end

   // The watchdog counts cycles in which no transfer happens on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // Idle cycles the sender puts in before its next byte. Most gaps are short,
   // a few are long, and now and then a burst of bytes goes out back to back.
   function automatic int next_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Time mostly creeps forward by a few milliseconds, sometimes crosses a
   // window boundary, and sometimes jumps anywhere, wrapping included.
   function automatic void advance_ms();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         ms_now += $urandom_range(0, 20);
      else if (roll < 85)
         ms_now += $urandom_range(21, 300);
      else if (roll < 95)
         ms_now += $urandom_range(900, 1500);
      else
         ms_now = $urandom;
   endfunction

   // Any byte but a newline; carriage returns turn up more often than chance.
   function automatic logic [7:0] line_body_byte();
      logic [7:0] b;
      if ($urandom_range(0, 99) < 8) return CH_CR;
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
      return b;
   endfunction

   // Line length: mostly short, sometimes up to the limit, sometimes past it.
   function automatic int pick_len(input int max_len);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, (max_len < 6) ? max_len : 6);
      if (roll < 90) return $urandom_range(0, max_len);
      return $urandom_range(max_len + 1, max_len + 3);
   endfunction

   // One byte transfer. Inputs change only at the falling edge, and valid
   // stays high from the previous byte when there is no gap.
   task automatic send_byte(input logic [7:0] b, input logic [CNT_W-1:0] now);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      req_now_ms  = now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_timed(input logic [7:0] b);
      advance_ms();
      send_byte(b, ms_now);
      phase_sent++;
   endtask

   task automatic send_random_line(input int body_len, input bit add_cr);
      for (int i = 0; i < body_len; i++) send_timed(line_body_byte());
      if (add_cr) send_timed(CH_CR);
      send_timed(CH_NL);
   endtask

   // Hold the sender back until every expected result has come out.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Register writes happen only with the block idle: drain first, then give
   // it time to finish any item that produced no result.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      int roll;
      int max_len;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings. A line of binary extremes with a trailing carriage
      // return, then a lone carriage return at the top of the time range,
      // which also restarts the window across the wrap.
      send_byte(8'h00, 32'd0);
      send_byte(8'hFF, 32'd0);
      send_byte(CH_CR, 32'd0);
      send_byte(CH_NL, 32'd0);
      send_byte(CH_CR, 32'hFFFF_FFFF);
      send_byte(CH_NL, 32'hFFFF_FFFF);
      // A bare newline, then two carriage returns of which only one is removed.
      send_byte(CH_NL, 32'hFFFF_FFFF);
      send_byte(CH_CR, 32'hFFFF_FFFF);
      send_byte(CH_CR, 32'hFFFF_FFFF);
      send_byte(CH_NL, 32'hFFFF_FFFF);

      // Echo on and a two-byte limit: the third byte overflows the store.
      write_reg(CSR_ECHO_ON, 10'd1);
      write_reg(CSR_MAX_LEN, 10'd2);
      send_byte(8'h61, 32'd100);
      send_byte(8'h62, 32'd100);
      send_byte(8'h63, 32'd100);
      send_byte(CH_NL, 32'd100);

      // A length limit of zero makes every ordinary byte overlong.
      write_reg(CSR_MAX_LEN, 10'd0);
      send_byte(8'h78, 32'd150);
      write_reg(CSR_MAX_LEN, 10'd63);

      // No lines allowed at all: the newline is a flood drop.
      write_reg(CSR_MAX_LINES, 10'd0);
      send_byte(CH_NL, 32'd200);

      // One line per window: the second line in the same second is dropped
      // and its bytes thrown away, and a second later the window restarts.
      write_reg(CSR_MAX_LINES, 10'd1);
      write_reg(CSR_ECHO_ON, 10'd0);
      send_byte(8'h71, 32'd5000);
      send_byte(CH_NL, 32'd5000);
      send_byte(8'h72, 32'd5000);
      send_byte(CH_NL, 32'd5000);
      send_byte(CH_NL, 32'd6000);

      // Disabling empties the store and ignores bytes; the newline after
      // enabling again sees an empty line.
      send_byte(8'h6B, 32'd6000);
      write_reg(CSR_ENABLE, 10'd0);
      send_byte(8'h7A, 32'd6000);
      write_reg(CSR_ENABLE, 10'd1);
      send_byte(CH_NL, 32'd7000);
      write_reg(CSR_MAX_LINES, 10'd1023);

      // Random phases, each under its own settings. Most traffic is whole
      // lines with random content; some is stray bytes, newlines included.
      ms_now = $urandom;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               write_reg(CSR_ECHO_ON, 10'd0);
               write_reg(CSR_MAX_LEN, 10'd63);
               write_reg(CSR_MAX_LINES, 10'd30);
               max_len = 63;
            end
            1: begin
               write_reg(CSR_ECHO_ON, 10'd1);
               write_reg(CSR_MAX_LINES, 10'd1023);
               max_len = 63;
            end
            2: begin
               max_len = $urandom_range(1, 8);
               write_reg(CSR_ECHO_ON, 10'($urandom_range(0, 1)));
               write_reg(CSR_MAX_LEN, 10'(max_len));
               write_reg(CSR_MAX_LINES, 10'($urandom_range(1, 4)));
            end
            3: begin
               max_len = 1;
               write_reg(CSR_ECHO_ON, 10'd1);
               write_reg(CSR_MAX_LEN, 10'd1);
               write_reg(CSR_MAX_LINES, 10'd2);
            end
            default: begin
               max_len = $urandom_range(1, 63);
               write_reg(CSR_ECHO_ON, 10'($urandom_range(0, 1)));
               write_reg(CSR_MAX_LEN, 10'(max_len));
               write_reg(CSR_MAX_LINES, 10'($urandom_range(0, 40)));
            end
         endcase
         phase_sent = 0;
         // A full-length line with echo gives the largest burst of results.
         if (p == 1) send_random_line(63, 1'b0);
         while (phase_sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
               send_timed(8'($urandom_range(0, 255)));
            else
               send_random_line(pick_len(max_len), $urandom_range(0, 99) < 30);
            if ($urandom_range(0, 29) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
